// File: hw/rtl/stta_pkg.sv
`default_nettype none

package stta_pkg;

    localparam int NUM_CPUS_DEFAULT  = 8;
    localparam int CPU_W             = 3;
    localparam int STATE_W           = 2;
    localparam int CNT_W             = 64;
    localparam int DIV_W             = 30;
    localparam int TICK_W            = 63;
    localparam int DVD_W             = 64;
    localparam int BITS_PER_CYCLE    = 2;

    localparam logic [DIV_W-1:0]   TICK_LEN_RESET    = 30'd4000000;
    localparam logic [STATE_W-1:0] RUN_STATE_RUNNING = 2'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SUM,
        ST_START_S,
        ST_DIV_S,
        ST_DIV_B,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic [CNT_W-1:0] last_blocked;
        logic [CNT_W-1:0] last_runnable;
        logic [CNT_W-1:0] last_offline;
        logic [DIV_W-1:0] stolen_rem;
        logic [DIV_W-1:0] blocked_rem;
    } cpu_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/stta_div.sv
`default_nettype none

module stta_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [stta_pkg::TICK_W-1:0]  dividend,
    input  wire logic [stta_pkg::DIV_W-1:0]   divisor,
    output stta_pkg::div_status_t             status,
    output logic      [stta_pkg::TICK_W-1:0]  quotient,
    output logic      [stta_pkg::DIV_W-1:0]   remainder
);
    import stta_pkg::*;

    localparam int STEPS  = DVD_W / BITS_PER_CYCLE;
    localparam int STEP_W = $clog2(STEPS);

    logic [DVD_W-1:0]  work_reg, work_next;
    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DIV_W-1:0]  step_rem;
    logic [DVD_W-1:0]  step_work;
    logic [DIV_W:0]    trial;
    logic              fits;

    // restoring division, two quotient bits per cycle
    always_comb begin
        step_rem  = rem_reg;
        step_work = work_reg;
        trial     = '0;
        fits      = 1'b0;
        for (int i = 0; i < BITS_PER_CYCLE; i++) begin
            trial     = {step_rem, step_work[DVD_W-1]};
            fits      = (trial >= {1'b0, divisor});
            step_work = {step_work[DVD_W-2:0], fits};
            step_rem  = fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
        end
    end

    always_comb begin
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            work_next = {1'b0, dividend};
            rem_next  = '0;
            cnt_next  = STEP_W'(STEPS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            work_next = step_work;
            rem_next  = step_rem;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = work_reg[TICK_W-1:0];
    assign remainder   = rem_reg;

endmodule

`default_nettype wire

// File: hw/rtl/stolen_time_tick_accounting_top.sv
`default_nettype none

// Channel  Dir  Handshake             Payload
// s_       in   s_tvalid / s_tready   s_tuser: cpu_index; s_tdata: run state, three totals
// m_       out  m_tvalid / m_tready   m_tuser: not_running_warning; m_tdata: steal, idle
// cfg_     in   cfg_valid / cfg_ready cfg_data: tick length in ns
//
// One event runs through the read, delta and sum steps, two back-to-back 64-bit divisions on
// the shared restoring divider (2 quotient bits per cycle) and the write-back to the per-CPU
// state memory.
// Reset (aresetn low, synchronous) clears all valid bits, so every CPU starts from zero.
// A new event is taken as soon as the previous result sits in the output register,
// even while m_tready is low; the block then stalls only before loading the next result.
module stolen_time_tick_accounting_top #(
    parameter int NUM_CPUS = stta_pkg::NUM_CPUS_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [1:0] run_state, [65:2] blocked_total, [129:66] runnable_total,
    // [193:130] offline_total, [199:194] zero
    input  wire logic [199:0] s_tdata,
    // [2:0] cpu_index
    input  wire logic [2:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [62:0] steal_ticks, [125:63] idle_ticks, [127:126] zero
    output logic      [127:0] m_tdata,
    // [0] not_running_warning
    output logic      [0:0]   m_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [29:0]  cfg_data
);
    import stta_pkg::*;

    localparam int AW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    state_t state_reg, state_next;

    logic [DIV_W-1:0]   tick_len_reg;
    logic [DIV_W-1:0]   divisor;

    logic [8:0]         cpu_fold;
    logic [AW-1:0]      cpu_addr;
    logic [AW-1:0]      addr_reg;
    logic               warn_reg;
    logic [CNT_W-1:0]   blk_reg, run_reg, off_reg;

    cpu_entry_t         mem [NUM_CPUS];
    cpu_entry_t         rd_reg;
    cpu_entry_t         prev;
    cpu_entry_t         wr_entry;
    logic [NUM_CPUS-1:0] valid_reg;
    logic               rd_valid_reg;

    logic [CNT_W-1:0]   d_blk_reg, d_run_reg, d_off_reg;
    logic [DIV_W-1:0]   rem_s_reg, rem_b_reg;
    logic [CNT_W-1:0]   stolen_sum, blocked_sum;
    logic [TICK_W-1:0]  stolen_reg, blocked_reg;
    logic [TICK_W-1:0]  steal_q_reg, idle_q_reg;

    logic [TICK_W-1:0]  out_steal_reg, out_idle_reg;
    logic               out_warn_reg;
    logic               m_tvalid_reg, m_tvalid_next;

    logic               in_accept;
    logic               div_start;
    logic               div_sel_b;
    logic               mem_we;
    logic               out_load;
    logic [TICK_W-1:0]  div_dividend;
    div_status_t        div_stat;
    logic [TICK_W-1:0]  div_q;
    logic [DIV_W-1:0]   div_r;

    // configuration
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_len_reg <= TICK_LEN_RESET;
        end else if (cfg_valid) begin
            tick_len_reg <= cfg_data;
        end
    end
    assign divisor = (tick_len_reg == '0) ? DIV_W'(1) : tick_len_reg;

    // fold cpu_index into range by repeated subtraction
    always_comb begin
        cpu_fold = {6'b0, s_tuser};
        for (int i = 0; i < 8; i++) begin
            if (cpu_fold >= 9'(NUM_CPUS)) begin
                cpu_fold = cpu_fold - 9'(NUM_CPUS);
            end
        end
    end
    assign cpu_addr  = cpu_fold[AW-1:0];
    assign in_accept = s_tvalid && s_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (s_tvalid) state_next = ST_DELTA;
            ST_DELTA:   state_next = ST_SUM;
            ST_SUM:     state_next = ST_START_S;
            ST_START_S: state_next = ST_DIV_S;
            ST_DIV_S:   if (div_stat.done) state_next = ST_DIV_B;
            ST_DIV_B:   if (div_stat.done) state_next = ST_WRITE;
            ST_WRITE:   state_next = ST_OUT;
            ST_OUT:     if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        div_sel_b = 1'b0;
        mem_we    = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:    s_tready = 1'b1;
            ST_START_S: div_start = 1'b1;
            ST_DIV_S: begin
                div_sel_b = 1'b1;
                div_start = div_stat.done;
            end
            ST_WRITE:   mem_we = 1'b1;
            ST_OUT:     out_load = !m_tvalid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // per-CPU state memory with registered read
    assign wr_entry.last_blocked  = blk_reg;
    assign wr_entry.last_runnable = run_reg;
    assign wr_entry.last_offline  = off_reg;
    assign wr_entry.stolen_rem    = rem_s_reg;
    assign wr_entry.blocked_rem   = rem_b_reg;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_reg <= mem[cpu_addr];
        end
        if (mem_we) begin
            mem[addr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                rd_valid_reg <= valid_reg[cpu_addr];
            end
            if (mem_we) begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // never-written entries read as zero
    assign prev = rd_valid_reg ? rd_reg : '0;

    assign stolen_sum  = d_run_reg + d_off_reg + {{(CNT_W-DIV_W){1'b0}}, rem_s_reg};
    assign blocked_sum = d_blk_reg + {{(CNT_W-DIV_W){1'b0}}, rem_b_reg};

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            addr_reg <= cpu_addr;
            warn_reg <= (s_tdata[1:0] != RUN_STATE_RUNNING);
            blk_reg  <= s_tdata[65:2];
            run_reg  <= s_tdata[129:66];
            off_reg  <= s_tdata[193:130];
        end
        if (state_reg == ST_DELTA) begin
            d_blk_reg <= blk_reg - prev.last_blocked;
            d_run_reg <= run_reg - prev.last_runnable;
            d_off_reg <= off_reg - prev.last_offline;
            rem_s_reg <= prev.stolen_rem;
            rem_b_reg <= prev.blocked_rem;
        end
        if (state_reg == ST_SUM) begin
            // negative as signed 64-bit clamps to zero
            stolen_reg  <= stolen_sum[CNT_W-1]  ? '0 : stolen_sum[TICK_W-1:0];
            blocked_reg <= blocked_sum[CNT_W-1] ? '0 : blocked_sum[TICK_W-1:0];
        end
        if (state_reg == ST_DIV_S && div_stat.done) begin
            steal_q_reg <= div_q;
            rem_s_reg   <= div_r;
        end
        if (state_reg == ST_DIV_B && div_stat.done) begin
            idle_q_reg <= div_q;
            rem_b_reg  <= div_r;
        end
        if (out_load) begin
            out_steal_reg <= steal_q_reg;
            out_idle_reg  <= idle_q_reg;
            out_warn_reg  <= warn_reg;
        end
    end

    assign div_dividend = div_sel_b ? blocked_reg : stolen_reg;

    stta_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (divisor),
        .status    (div_stat),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_idle_reg, out_steal_reg};
    assign m_tuser  = out_warn_reg;

`ifndef SYNTH
    a_idle_div_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy && !div_stat.done)
        else $error("divider active while accepting a new event");

    a_done_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV_S || state_reg == ST_DIV_B))
        else $error("divider finished outside a division step");

    a_load_then_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid && s_tready)
        else $error("result load did not present output and reopen input");

    a_write_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> $past(state_reg) == ST_DIV_B && $past(div_stat.done))
        else $error("state write-back without completed blocked division");
`endif

endmodule

`default_nettype wire
